>>> rtl/sca_pkg.sv
// Shared types and constants of the segment chain allocator.
// Used by sca_ram's instance in the top level and by segment_chain_allocator.
`timescale 1ns / 1ps
package sca_pkg;

    localparam int ARENA_BASE       = 256;
    localparam int ARENA_PARAGRAPHS = 4096;

    // Header index width and the width of a chain pointer before range check.
    localparam int IDX_W = $clog2(ARENA_PARAGRAPHS);
    localparam int PTR_W = 17;
    localparam int SEG_W = 16;

    localparam logic [PTR_W-1:0] ARENA_END   = PTR_W'(ARENA_PARAGRAPHS);
    localparam logic [PTR_W-1:0] FREE_MIN    = PTR_W'(ARENA_BASE + 1);
    localparam logic [IDX_W-1:0] CLR_LAST    = IDX_W'(ARENA_PARAGRAPHS - 1);
    localparam logic [SEG_W-1:0] BASE_SEG    = SEG_W'(ARENA_BASE);

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_MID  = 2'd1;
    localparam logic [1:0] MARK_LAST = 2'd2;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FREE    = 2'd1;
    localparam logic [1:0] KIND_RESIZE  = 2'd2;
    localparam logic [1:0] KIND_FREEALL = 2'd3;

    localparam logic [1:0] STRAT_FIRST   = 2'd0;
    localparam logic [1:0] STRAT_BEST    = 2'd1;
    localparam logic [1:0] STRAT_LAST    = 2'd2;
    localparam logic [1:0] STRAT_INVALID = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NOMEM   = 3'd1;
    localparam logic [2:0] ERR_HDR     = 3'd2;
    localparam logic [2:0] ERR_BADADDR = 3'd3;
    localparam logic [2:0] ERR_CHAIN   = 3'd4;

    typedef struct packed {
        logic [1:0]       mark;
        logic [SEG_W-1:0] size;
        logic [SEG_W-1:0] owner;
    } t_hdr;

    localparam t_hdr HDR_CLEAR = '{mark: MARK_NONE, size: '0, owner: '0};
    localparam t_hdr HDR_RESET = '{mark: MARK_LAST, size: SEG_W'(ARENA_PARAGRAPHS - 1),
                                   owner: '0};

    // Data segment of the block whose header sits at index idx.
    function automatic logic [SEG_W-1:0] seg_of(logic [IDX_W-1:0] idx);
        return BASE_SEG + SEG_W'(idx) + SEG_W'(1);
    endfunction

endpackage

>>> rtl/sca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/segment_chain_allocator.sv
// Segment chain allocator top level: request sequencer over the header RAM.
// Depends on sca_pkg and sca_ram.
`timescale 1ns / 1ps
// Paragraph allocator over a chain of block headers kept in one RAM with one
// header per arena paragraph. After reset the block runs a clearing pass over
// all ARENA_PARAGRAPHS headers before it takes its first request. Every
// request is carried out by one sequencer around the single RAM port pair:
// an allocate runs a free-block merge over the chain and then a chain walk,
// a free checks and rewrites one header, a resize runs a merge before it
// resizes the header, and a free-by-owner runs a walk and then a merge. A
// request is taken only while the sequencer is idle; its result beat then
// waits in an output register while the next request is taken.
module segment_chain_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic [sca_pkg::SEG_W-1:0] i_segment,
    input  logic [sca_pkg::SEG_W-1:0] i_paragraphs,
    input  logic [sca_pkg::SEG_W-1:0] i_owner,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_ok,
    output logic [sca_pkg::SEG_W-1:0] o_result_segment,
    output logic [sca_pkg::SEG_W-1:0] o_avail_paragraphs,
    output logic [2:0]               o_error,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_alloc_strategy
);
    import sca_pkg::*;

    typedef enum logic [17:0] {
        S_CLR      = 18'h00001,
        S_IDLE     = 18'h00002,
        S_FREE_CHK = 18'h00004,
        S_RES_CHK  = 18'h00008,
        S_RES_HDR  = 18'h00010,
        S_RES_NXT  = 18'h00020,
        S_RES_GROW = 18'h00040,
        S_M_START  = 18'h00080,
        S_M_HEAD   = 18'h00100,
        S_M_STEP   = 18'h00200,
        S_M_NEXT   = 18'h00400,
        S_M_WB     = 18'h00800,
        S_W_RD     = 18'h01000,
        S_W_CHK    = 18'h02000,
        S_W_END    = 18'h04000,
        S_WR1      = 18'h08000,
        S_WR2      = 18'h10000,
        S_FIN      = 18'h20000
    } t_state;

    // What follows a successful merge pass.
    typedef enum logic [1:0] {
        CTX_ALLOC = 2'd0,
        CTX_RES1  = 2'd1,
        CTX_RES2  = 2'd2,
        CTX_FALL  = 2'd3
    } t_ctx;

    t_state r_state, n_state, r_wnext, n_wnext;
    t_ctx   r_ctx, n_ctx;

    logic [1:0]       r_kind, n_kind;
    logic [1:0]       r_strat, n_strat;
    logic [SEG_W-1:0] r_req, n_req;
    logic [SEG_W-1:0] r_own, n_own;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_from, n_from;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0]       r_mark, n_mark;
    logic [SEG_W-1:0] r_size, n_size;
    logic [SEG_W-1:0] r_owner, n_owner;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [PTR_W-1:0] r_total, n_total;
    logic [SEG_W-1:0] r_big, n_big;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_fi, n_fi;
    logic [SEG_W-1:0] r_fs, n_fs;
    logic [1:0]       r_fm, n_fm;
    logic [IDX_W-1:0] r_w1a, n_w1a, r_w2a, n_w2a;
    t_hdr             r_w1d, n_w1d, r_w2d, n_w2d;

    logic             r_p_ok, n_p_ok;
    logic [SEG_W-1:0] r_p_seg, n_p_seg;
    logic [SEG_W-1:0] r_p_avail, n_p_avail;
    logic [2:0]       r_p_err, n_p_err;

    logic             r_out_valid, n_out_valid;
    logic             r_ok, n_ok;
    logic [SEG_W-1:0] r_rseg, n_rseg;
    logic [SEG_W-1:0] r_avail, n_avail;
    logic [2:0]       r_err, n_err;

    logic             ram_we;
    logic [IDX_W-1:0] ram_wa, ram_ra;
    t_hdr             ram_wd;
    logic [$bits(t_hdr)-1:0] ram_rdata;
    t_hdr             d;

    logic [SEG_W-1:0] in_hi;
    logic             in_hi_ok;
    logic [IDX_W-1:0] wptr;
    logic [PTR_W-1:0] walk_next, merge_next, grow_next;
    logic [IDX_W-1:0] carve_at;

    sca_ram #(
        .WIDTH ($bits(t_hdr)),
        .DEPTH (ARENA_PARAGRAPHS)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rdata)
    );

    assign d          = t_hdr'(ram_rdata);
    assign in_hi      = i_segment - BASE_SEG - SEG_W'(1);
    assign in_hi_ok   = PTR_W'(in_hi) < ARENA_END;
    assign wptr       = r_ptr[IDX_W-1:0];
    assign walk_next  = PTR_W'(wptr) + PTR_W'(d.size) + PTR_W'(1);
    assign merge_next = PTR_W'(r_idx) + PTR_W'(r_size) + PTR_W'(1);
    assign grow_next  = PTR_W'(r_hi) + PTR_W'(d.size) + PTR_W'(1);
    assign carve_at   = r_fi + IDX_W'(r_fs - r_req);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_ok               = r_ok;
    assign o_result_segment   = r_rseg;
    assign o_avail_paragraphs = r_avail;
    assign o_error            = r_err;

    always_comb begin
        logic wdone;
        n_state = r_state;  n_wnext = r_wnext;  n_ctx = r_ctx;
        n_kind = r_kind;    n_req = r_req;      n_own = r_own;
        n_hi = r_hi;        n_from = r_from;    n_clr = r_clr;
        n_idx = r_idx;      n_mark = r_mark;    n_size = r_size;
        n_owner = r_owner;  n_ptr = r_ptr;      n_total = r_total;
        n_big = r_big;      n_found = r_found;  n_fi = r_fi;
        n_fs = r_fs;        n_fm = r_fm;
        n_w1a = r_w1a;      n_w1d = r_w1d;      n_w2a = r_w2a;  n_w2d = r_w2d;
        n_p_ok = r_p_ok;    n_p_seg = r_p_seg;  n_p_avail = r_p_avail;
        n_p_err = r_p_err;
        n_ok = r_ok;        n_rseg = r_rseg;    n_avail = r_avail;  n_err = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_strat = r_strat;
        ram_we = 1'b0;
        ram_wa = '0;
        ram_wd = HDR_CLEAR;
        ram_ra = '0;
        wdone  = 1'b0;

        if (i_cfg_valid && i_alloc_strategy != STRAT_INVALID) begin
            n_strat = i_alloc_strategy;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                ram_wa = r_clr;
                ram_wd = (r_clr == '0) ? HDR_RESET : HDR_CLEAR;
                n_clr  = r_clr + IDX_W'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind    = i_kind;
                    n_req     = i_paragraphs;
                    n_own     = i_owner;
                    n_hi      = in_hi[IDX_W-1:0];
                    n_p_ok    = 1'b0;
                    n_p_seg   = '0;
                    n_p_avail = '0;
                    n_p_err   = ERR_NONE;
                    unique case (i_kind)
                        KIND_ALLOC: begin
                            n_ctx   = CTX_ALLOC;
                            n_from  = '0;
                            n_state = S_M_START;
                        end
                        KIND_FREE: begin
                            if (PTR_W'(i_segment) < FREE_MIN || !in_hi_ok) begin
                                n_p_err = ERR_BADADDR;
                                n_state = S_FIN;
                            end else begin
                                ram_ra  = in_hi[IDX_W-1:0];
                                n_state = S_FREE_CHK;
                            end
                        end
                        KIND_RESIZE: begin
                            if (!in_hi_ok) begin
                                n_p_err = ERR_HDR;
                                n_state = S_FIN;
                            end else begin
                                ram_ra  = in_hi[IDX_W-1:0];
                                n_state = S_RES_CHK;
                            end
                        end
                        default: begin
                            n_ptr   = '0;
                            n_state = S_W_RD;
                        end
                    endcase
                end
            end

            S_FREE_CHK: begin
                if (d.mark == MARK_NONE) begin
                    n_p_err = ERR_BADADDR;
                end else begin
                    ram_we = 1'b1;
                    ram_wa = r_hi;
                    ram_wd = '{mark: d.mark, size: d.size, owner: '0};
                    n_p_ok = 1'b1;
                end
                n_state = S_FIN;
            end

            S_RES_CHK: begin
                if (d.mark == MARK_NONE) begin
                    n_p_err = ERR_HDR;
                    n_state = S_FIN;
                end else begin
                    n_from  = r_hi;
                    n_ctx   = CTX_RES1;
                    n_state = S_M_START;
                end
            end

            S_RES_HDR: begin
                n_total = PTR_W'(d.size);
                n_mark  = d.mark;
                if (r_req <= d.size) begin
                    n_ctx  = CTX_RES2;
                    n_from = '0;
                    if (r_req < d.size) begin
                        n_w1a   = r_hi + IDX_W'(r_req) + IDX_W'(1);
                        n_w1d   = '{mark: d.mark, size: d.size - r_req - SEG_W'(1), owner: '0};
                        n_w2a   = r_hi;
                        n_w2d   = '{mark: MARK_MID, size: r_req, owner: r_own};
                        n_wnext = S_M_START;
                        n_state = S_WR1;
                    end else begin
                        n_state = S_M_START;
                    end
                end else begin
                    n_ptr = grow_next;
                    if (d.mark != MARK_LAST && grow_next < ARENA_END) begin
                        ram_ra  = grow_next[IDX_W-1:0];
                        n_state = S_RES_NXT;
                    end else begin
                        n_state = S_RES_GROW;
                    end
                end
            end

            S_RES_NXT: begin
                // The following block is absorbed when it is free.
                if (d.mark != MARK_NONE && d.owner == '0) begin
                    n_total = r_total + PTR_W'(d.size) + PTR_W'(1);
                    n_mark  = d.mark;
                    ram_we  = 1'b1;
                    ram_wa  = wptr;
                    ram_wd  = HDR_CLEAR;
                end
                n_state = S_RES_GROW;
            end

            S_RES_GROW: begin
                if (PTR_W'(r_req) < r_total) begin
                    n_w1a   = r_hi + IDX_W'(r_req) + IDX_W'(1);
                    n_w1d   = '{mark: r_mark, size: SEG_W'(r_total - PTR_W'(r_req) - PTR_W'(1)),
                                owner: '0};
                    n_w2a   = r_hi;
                    n_w2d   = '{mark: MARK_MID, size: r_req, owner: r_own};
                    n_wnext = S_FIN;
                    n_p_ok  = 1'b1;
                    n_state = S_WR1;
                end else begin
                    ram_we = 1'b1;
                    ram_wa = r_hi;
                    ram_wd = '{mark: r_mark, size: r_total[SEG_W-1:0], owner: r_own};
                    if (PTR_W'(r_req) == r_total) begin
                        n_p_ok = 1'b1;
                    end else begin
                        n_p_avail = r_total[SEG_W-1:0];
                        n_p_err   = ERR_NOMEM;
                    end
                    n_state = S_FIN;
                end
            end

            S_M_START: begin
                ram_ra  = '0;
                n_state = S_M_HEAD;
            end

            S_M_HEAD: begin
                if (d.mark == MARK_NONE) begin
                    n_p_err = ERR_CHAIN;
                    n_state = S_FIN;
                end else begin
                    n_idx   = '0;
                    n_mark  = d.mark;
                    n_size  = d.size;
                    n_owner = d.owner;
                    n_state = S_M_STEP;
                end
            end

            S_M_STEP: begin
                if (r_mark == MARK_LAST) begin
                    unique case (r_ctx)
                        CTX_ALLOC: begin
                            n_ptr   = '0;
                            n_big   = '0;
                            n_found = 1'b0;
                            n_state = S_W_RD;
                        end
                        CTX_RES1: begin
                            ram_ra  = r_hi;
                            n_state = S_RES_HDR;
                        end
                        default: begin
                            n_p_ok  = 1'b1;
                            n_state = S_FIN;
                        end
                    endcase
                end else if (r_mark != MARK_MID || merge_next >= ARENA_END) begin
                    n_p_err = ERR_CHAIN;
                    n_state = S_FIN;
                end else begin
                    ram_ra  = merge_next[IDX_W-1:0];
                    n_ptr   = merge_next;
                    n_state = S_M_NEXT;
                end
            end

            S_M_NEXT: begin
                if (d.mark == MARK_NONE) begin
                    n_p_err = ERR_CHAIN;
                    n_state = S_FIN;
                end else if (r_idx >= r_from && r_owner == '0 && d.owner == '0) begin
                    ram_we  = 1'b1;
                    ram_wa  = wptr;
                    ram_wd  = HDR_CLEAR;
                    n_size  = r_size + d.size + SEG_W'(1);
                    n_mark  = d.mark;
                    n_state = S_M_WB;
                end else begin
                    n_idx   = wptr;
                    n_mark  = d.mark;
                    n_size  = d.size;
                    n_owner = d.owner;
                    n_state = S_M_STEP;
                end
            end

            S_M_WB: begin
                ram_we  = 1'b1;
                ram_wa  = r_idx;
                ram_wd  = '{mark: r_mark, size: r_size, owner: r_owner};
                n_state = S_M_STEP;
            end

            S_W_RD: begin
                if (r_ptr >= ARENA_END) begin
                    n_p_err = ERR_CHAIN;
                    n_state = S_FIN;
                end else begin
                    ram_ra  = wptr;
                    n_state = S_W_CHK;
                end
            end

            S_W_CHK: begin
                if (d.mark == MARK_NONE) begin
                    n_p_err = ERR_CHAIN;
                    n_state = S_FIN;
                end else begin
                    if (r_kind == KIND_ALLOC) begin
                        if (d.owner == '0) begin
                            priority if (d.size < r_req) begin
                                if (r_big < d.size) begin
                                    n_big = d.size;
                                end
                            end else if (d.size == r_req && r_strat != STRAT_LAST) begin
                                ram_we  = 1'b1;
                                ram_wa  = wptr;
                                ram_wd  = '{mark: d.mark, size: d.size, owner: r_own};
                                n_p_ok  = 1'b1;
                                n_p_seg = seg_of(wptr);
                                n_state = S_FIN;
                                wdone   = 1'b1;
                            end else if (r_strat == STRAT_FIRST) begin
                                n_w1a   = wptr + IDX_W'(r_req) + IDX_W'(1);
                                n_w1d   = '{mark: d.mark, size: d.size - r_req - SEG_W'(1),
                                            owner: '0};
                                n_w2a   = wptr;
                                n_w2d   = '{mark: MARK_MID, size: r_req, owner: r_own};
                                n_wnext = S_FIN;
                                n_p_ok  = 1'b1;
                                n_p_seg = seg_of(wptr);
                                n_state = S_WR1;
                                wdone   = 1'b1;
                            end else if (r_strat == STRAT_BEST) begin
                                if (!r_found || d.size < r_fs) begin
                                    n_found = 1'b1;
                                    n_fi    = wptr;
                                    n_fs    = d.size;
                                    n_fm    = d.mark;
                                end
                            end else begin
                                n_found = 1'b1;
                                n_fi    = wptr;
                                n_fs    = d.size;
                                n_fm    = d.mark;
                            end
                        end
                    end else if (d.owner == r_own) begin
                        ram_we = 1'b1;
                        ram_wa = wptr;
                        ram_wd = '{mark: d.mark, size: d.size, owner: '0};
                    end
                    if (!wdone) begin
                        priority if (d.mark == MARK_LAST) begin
                            n_state = S_W_END;
                        end else if (d.mark != MARK_MID) begin
                            n_p_err = ERR_CHAIN;
                            n_state = S_FIN;
                        end else begin
                            n_ptr   = walk_next;
                            n_state = S_W_RD;
                        end
                    end
                end
            end

            S_W_END: begin
                if (r_kind != KIND_ALLOC) begin
                    n_ctx   = CTX_FALL;
                    n_from  = '0;
                    n_state = S_M_START;
                end else if (r_found) begin
                    n_p_ok  = 1'b1;
                    n_wnext = S_FIN;
                    priority if (r_strat == STRAT_BEST) begin
                        n_w1a   = r_fi + IDX_W'(r_req) + IDX_W'(1);
                        n_w1d   = '{mark: r_fm, size: r_fs - r_req - SEG_W'(1), owner: '0};
                        n_w2a   = r_fi;
                        n_w2d   = '{mark: MARK_MID, size: r_req, owner: r_own};
                        n_p_seg = seg_of(r_fi);
                        n_state = S_WR1;
                    end else if (r_fs == r_req) begin
                        n_w2a   = r_fi;
                        n_w2d   = '{mark: r_fm, size: r_fs, owner: r_own};
                        n_p_seg = seg_of(r_fi);
                        n_state = S_WR2;
                    end else begin
                        // Last fit carves the request from the top of the block.
                        n_w1a   = carve_at;
                        n_w1d   = '{mark: r_fm, size: r_req, owner: r_own};
                        n_w2a   = r_fi;
                        n_w2d   = '{mark: MARK_MID, size: r_fs - r_req - SEG_W'(1), owner: '0};
                        n_p_seg = seg_of(carve_at);
                        n_state = S_WR1;
                    end
                end else begin
                    n_p_avail = r_big;
                    n_p_err   = ERR_NOMEM;
                    n_state   = S_FIN;
                end
            end

            S_WR1: begin
                ram_we  = 1'b1;
                ram_wa  = r_w1a;
                ram_wd  = r_w1d;
                n_state = S_WR2;
            end

            S_WR2: begin
                ram_we  = 1'b1;
                ram_wa  = r_w2a;
                ram_wd  = r_w2d;
                n_state = r_wnext;
            end

            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_ok        = r_p_ok;
                    n_rseg      = r_p_seg;
                    n_avail     = r_p_avail;
                    n_err       = r_p_err;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_strat     <= STRAT_FIRST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_strat     <= n_strat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wnext   <= n_wnext;   r_ctx     <= n_ctx;
        r_kind    <= n_kind;    r_req     <= n_req;    r_own    <= n_own;
        r_hi      <= n_hi;      r_from    <= n_from;
        r_idx     <= n_idx;     r_mark    <= n_mark;   r_size   <= n_size;
        r_owner   <= n_owner;   r_ptr     <= n_ptr;    r_total  <= n_total;
        r_big     <= n_big;     r_found   <= n_found;  r_fi     <= n_fi;
        r_fs      <= n_fs;      r_fm      <= n_fm;
        r_w1a     <= n_w1a;     r_w1d     <= n_w1d;
        r_w2a     <= n_w2a;     r_w2d     <= n_w2d;
        r_p_ok    <= n_p_ok;    r_p_seg   <= n_p_seg;
        r_p_avail <= n_p_avail; r_p_err   <= n_p_err;
        r_ok      <= n_ok;      r_rseg    <= n_rseg;
        r_avail   <= n_avail;   r_err     <= n_err;
    end

    a_ok_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> (o_error == ERR_NONE))
        else $error("successful result beat carries an error code");

    a_fail_no_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_result_segment == '0))
        else $error("failed result beat carries a segment");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one is still in work");

    a_avail_only_nomem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_avail_paragraphs != '0) |-> (o_error == ERR_NOMEM))
        else $error("available size reported without an insufficient memory error");

endmodule
